### design/ptc_pkg.sv
package ptc_pkg;

  // Status codes carried on the result word
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIVZ  = 2'd1,
    ST_PSAT  = 2'd2
  } status_t;

  // Sideband bits carried alongside a divider
  localparam int unsigned SB_W = 64;
  localparam int unsigned DIV_STEPS = 32;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_OSS   = 2'd0;
  localparam logic [1:0] REG_AC    = 2'd1;
  localparam logic [1:0] REG_BT    = 2'd2;
  localparam logic [1:0] REG_MCMD  = 2'd3;

  localparam logic [31:0] B6_OFS    = 32'd4000;
  localparam logic [31:0] C3038     = 32'd3038;
  localparam logic [31:0] CM7357    = 32'hFFFF_E343;
  localparam logic [31:0] C3791     = 32'd3791;
  localparam logic [31:0] C50000    = 32'd50000;
  localparam logic [31:0] C32768    = 32'd32768;
  localparam logic [31:0] P_MAX     = 32'd262143;

  // Arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // Sign-extend a 16-bit coefficient
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

### design/ptc_div.sv
module ptc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [31:0]               num,
  input  logic [31:0]               den,
  input  logic [ptc_pkg::SB_W-1:0]  in_sb,
  output logic                      out_valid,
  output logic [31:0]               quo,
  output logic [ptc_pkg::SB_W-1:0]  out_sb
);
  import ptc_pkg::*;

  logic             v_r   [0:DIV_STEPS];
  logic [31:0]      rem_r [0:DIV_STEPS];
  logic [31:0]      nq_r  [0:DIV_STEPS];
  logic [31:0]      d_r   [0:DIV_STEPS];
  logic [SB_W-1:0]  sb_r  [0:DIV_STEPS];

  // Stage zero is the input word itself
  assign v_r[0]   = in_valid;
  assign rem_r[0] = '0;
  assign nq_r[0]  = num;
  assign d_r[0]   = den;
  assign sb_r[0]  = in_sb;

  // One restoring quotient bit per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;
    assign trial = {rem_r[k-1], nq_r[k-1][31]};
    assign ge    = trial >= {1'b0, d_r[k-1]};
    assign diff  = trial - {1'b0, d_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[31:0] : trial[31:0];
        nq_r[k]  <= {nq_r[k-1][30:0], ge};
        d_r[k]   <= d_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
    end
  end

  assign out_valid = v_r[DIV_STEPS];
  assign quo       = nq_r[DIV_STEPS];
  assign out_sb    = sb_r[DIV_STEPS];

endmodule

### design/pressure_temperature_compensation.sv
// Barometer compensation pipeline: each input word (raw temperature, raw 24-bit
// pressure) yields one result word with temperature in tenths of a degree,
// pressure in pascal and a status (ok, zero divisor, pressure saturated).
// A new word is taken every cycle while the pipeline is not halted; it runs
// through two 32-stage bit-per-stage dividers and the multiplier stages around them.
// The whole pipeline advances together and halts while a finished result
// waits on out_tready. Calibration registers are written over the APB port
// and must not change while words are in flight.
module pressure_temperature_compensation (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: temperature_raw[15:0], pressure_raw[39:16]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: temperature_tenths[15:0], pressure_pa[33:16], zero[39:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import ptc_pkg::*;

  logic        en;
  logic [1:0]  oss_r;
  logic [63:0] cal_ac_r, cal_bt_r;
  logic [31:0] cal_mc_md_r;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign ac1 = sx16(cal_ac_r[15:0]);
  assign ac2 = sx16(cal_ac_r[31:16]);
  assign ac3 = sx16(cal_ac_r[47:32]);
  assign ac4 = {16'd0, cal_ac_r[63:48]};
  assign ac5 = {16'd0, cal_bt_r[15:0]};
  assign ac6 = {16'd0, cal_bt_r[31:16]};
  assign b1  = sx16(cal_bt_r[47:32]);
  assign b2  = sx16(cal_bt_r[63:48]);
  assign mc  = sx16(cal_mc_md_r[15:0]);
  assign md  = sx16(cal_mc_md_r[31:16]);

  // Configuration registers
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oss_r       <= 2'd3;
      cal_ac_r    <= '0;
      cal_bt_r    <= '0;
      cal_mc_md_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[4:3])
        REG_OSS:  oss_r       <= cfg_pwdata[1:0];
        REG_AC:   cal_ac_r    <= cfg_pwdata;
        REG_BT:   cal_bt_r    <= cfg_pwdata;
        REG_MCMD: cal_mc_md_r <= cfg_pwdata[31:0];
        default:  oss_r       <= oss_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      REG_OSS:  cfg_prdata = {62'd0, oss_r};
      REG_AC:   cfg_prdata = cal_ac_r;
      REG_BT:   cfg_prdata = cal_bt_r;
      REG_MCMD: cfg_prdata = {32'd0, cal_mc_md_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // Advance all stages when the output slot is free or being taken
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // Stage 1: (UT - AC6) * AC5
  logic        v1_r;
  logic [31:0] p1_r, up1_r;
  logic [31:0] ut_w, up_w;
  assign ut_w = {16'd0, in_tdata[15:0]};
  assign up_w = {8'd0, in_tdata[39:16]} >> (4'd8 - {2'd0, oss_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= (ut_w - ac6) * ac5;
      up1_r <= up_w;
    end
  end

  // Stage 2: X1 and the divisor for B5
  logic        v2_r;
  logic [31:0] x1_2_r, div2_r, up2_r;
  logic [31:0] x1_w;
  assign x1_w = asr32(p1_r, 15);
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1_2_r <= x1_w;
      div2_r <= x1_w + md;
      up2_r  <= up1_r;
    end
  end

  // Divider A: (MC << 11) / (X1 + MD), signed, via magnitudes
  logic [31:0] mcs, da_num, da_den, qa;
  logic        na, nb, va;
  logic [SB_W-1:0] sba_in, sba_out;
  assign mcs    = mc << 11;
  assign na     = mcs[31];
  assign nb     = div2_r[31];
  assign da_num = na ? (32'd0 - mcs) : mcs;
  assign da_den = nb ? (32'd0 - div2_r) : div2_r;
  assign sba_in = {x1_2_r, up2_r[23:0], 6'd0, (div2_r == 32'd0), (na != nb)};

  ptc_div u_div_a (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v2_r), .num(da_num), .den(da_den), .in_sb(sba_in),
    .out_valid(va), .quo(qa), .out_sb(sba_out)
  );

  // Stage 3: B5 and B6
  logic        v3_r, dz3_r;
  logic [31:0] b5_3_r, b6_3_r, up3_r;
  logic [31:0] x2a, b5_w;
  assign x2a  = sba_out[0] ? (32'd0 - qa) : qa;
  assign b5_w = sba_out[63:32] + x2a;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b5_3_r <= b5_w;
      b6_3_r <= b5_w - B6_OFS;
      up3_r  <= {8'd0, sba_out[31:8]};
      dz3_r  <= sba_out[1];
    end
  end

  // Stage 4: B6 products and temperature
  logic        v4_r, dz4_r;
  logic [31:0] sqp4_r, a2p4_r, a3p4_r, b6_4_r, up4_r;
  logic [15:0] t4_r;
  logic [31:0] tw;
  assign tw = asr32(b5_3_r + 32'd8, 4);
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqp4_r <= b6_3_r * b6_3_r;
      a2p4_r <= ac2 * b6_3_r;
      a3p4_r <= ac3 * b6_3_r;
      b6_4_r <= b6_3_r;
      up4_r  <= up3_r;
      dz4_r  <= dz3_r;
      if ($signed(tw) > 32'sd32767) t4_r <= 16'h7FFF;
      else if ($signed(tw) < -32'sd32768) t4_r <= 16'h8000;
      else t4_r <= tw[15:0];
    end
  end

  // Stage 5: B2*SQ and B1*SQ
  logic        v5_r, dz5_r;
  logic [31:0] b2s5_r, b1s5_r, a2p5_r, a3p5_r, up5_r;
  logic [15:0] t5_r;
  logic [31:0] sq_w;
  assign sq_w = asr32(sqp4_r, 12);
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b2s5_r <= b2 * sq_w;
      b1s5_r <= b1 * sq_w;
      a2p5_r <= a2p4_r;
      a3p5_r <= a3p4_r;
      up5_r  <= up4_r;
      t5_r   <= t4_r;
      dz5_r  <= dz4_r;
    end
  end

  // Stage 6: B3 and the B4 term
  logic        v6_r, dz6_r;
  logic [31:0] b3_6_r, x3b6_r, up6_r;
  logic [15:0] t6_r;
  logic [31:0] x3a_w, b3v_w, x3b_w;
  assign x3a_w = asr32(b2s5_r, 11) + asr32(a2p5_r, 11);
  assign b3v_w = (((ac1 << 2) + x3a_w) << oss_r) + 32'd2;
  assign x3b_w = asr32(asr32(a3p5_r, 13) + asr32(b1s5_r, 16) + 32'd2, 2);
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // signed divide by four, truncating toward zero
      b3_6_r <= asr32(b3v_w + (b3v_w[31] ? 32'd3 : 32'd0), 2);
      x3b6_r <= x3b_w;
      up6_r  <= up5_r;
      t6_r   <= t5_r;
      dz6_r  <= dz5_r;
    end
  end

  // Stage 7: B4 and B7
  logic        v7_r, dz7_r;
  logic [31:0] b4_7_r, b7_7_r;
  logic [15:0] t7_r;
  logic [31:0] b4p_w;
  assign b4p_w = ac4 * (x3b6_r + C32768);
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4_7_r <= b4p_w >> 15;
      b7_7_r <= (up6_r - b3_6_r) * (C50000 >> oss_r);
      t7_r   <= t6_r;
      dz7_r  <= dz6_r;
    end
  end

  // Divider B: B7 / B4, unsigned, with the doubling placed by B7's top bit
  logic        big, vb;
  logic [31:0] db_num, qb;
  logic [SB_W-1:0] sbb_in, sbb_out;
  assign big    = b7_7_r[31];
  assign db_num = big ? b7_7_r : (b7_7_r << 1);
  assign sbb_in = {46'd0, t7_r, (dz7_r || (b4_7_r == 32'd0)), big};

  ptc_div u_div_b (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v7_r), .num(db_num), .den(b4_7_r), .in_sb(sbb_in),
    .out_valid(vb), .quo(qb), .out_sb(sbb_out)
  );

  // Stage 8: P
  logic        v8_r, dz8_r;
  logic [31:0] p8_r;
  logic [15:0] t8_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p8_r  <= sbb_out[0] ? (qb << 1) : qb;
      t8_r  <= sbb_out[17:2];
      dz8_r <= sbb_out[1];
    end
  end

  // Stage 9: (P>>8)^2 and -7357*P
  logic        v9_r, dz9_r;
  logic [31:0] sq9_r, x2_9_r, p9_r;
  logic [15:0] t9_r;
  logic [31:0] p8s;
  assign p8s = asr32(p8_r, 8);
  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq9_r  <= p8s * p8s;
      x2_9_r <= CM7357 * p8_r;
      p9_r   <= p8_r;
      t9_r   <= t8_r;
      dz9_r  <= dz8_r;
    end
  end

  // Stage 10: times 3038
  logic        v10_r, dz10_r;
  logic [31:0] x1m10_r, x2_10_r, p10_r;
  logic [15:0] t10_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v10_r <= 1'b0;
    else if (en) v10_r <= v9_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1m10_r <= sq9_r * C3038;
      x2_10_r <= x2_9_r;
      p10_r   <= p9_r;
      t10_r   <= t9_r;
      dz10_r  <= dz9_r;
    end
  end

  // Stage 11: final correction, saturation and the output word
  logic [31:0] pf_w;
  logic [15:0] t_o_r;
  logic [17:0] p_o_r;
  status_t     st_o_r;
  logic        ov_r;
  assign pf_w = p10_r + asr32(asr32(x1m10_r, 16) + asr32(x2_10_r, 16) + C3791, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= v10_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (dz10_r) begin
        t_o_r  <= '0;
        p_o_r  <= '0;
        st_o_r <= ST_DIVZ;
      end else if (pf_w[31]) begin
        t_o_r  <= t10_r;
        p_o_r  <= '0;
        st_o_r <= ST_PSAT;
      end else if (pf_w > P_MAX) begin
        t_o_r  <= t10_r;
        p_o_r  <= P_MAX[17:0];
        st_o_r <= ST_PSAT;
      end else begin
        t_o_r  <= t10_r;
        p_o_r  <= pf_w[17:0];
        st_o_r <= ST_OK;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, p_o_r, t_o_r};
  assign out_tuser  = st_o_r;

`ifndef NO_ASSERTIONS
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_DIVZ |-> out_tdata[33:0] == '0)
    else $error("zero divisor result carries nonzero data");
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (out_tready || !out_tvalid))
    else $error("input ready does not follow pipeline advance");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OK |-> out_tdata[39:34] == '0)
    else $error("padding bits set");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ptc_pkg::*;

  // One compensated reading as it leaves the block
  typedef struct packed {
    logic [15:0] temp_tenths;
    logic [17:0] press_pa;
    status_t     status;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the calibration registers
  logic [1:0]  oss_sh = 2'd3;
  logic [63:0] cal_ac_sh = '0;
  logic [63:0] cal_bt_sh = '0;
  logic [31:0] cal_mcmd_sh = '0;

  logic [39:0] pending_words[$];
  reading_t    expected_readings[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          holdoff_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;

  pressure_temperature_compensation u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Sign-extend a 16-bit coefficient
  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  // Signed 32-bit divide truncating toward zero, wrapping on overflow
  function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Run the calibration chain on one raw word with the shadow registers
  function automatic reading_t compensate(input logic [39:0] word);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, divisor;
    int          t, ps;
    reading_t    r;
    ac1 = ext16(cal_ac_sh[15:0]);
    ac2 = ext16(cal_ac_sh[31:16]);
    ac3 = ext16(cal_ac_sh[47:32]);
    ac4 = {16'd0, cal_ac_sh[63:48]};
    ac5 = {16'd0, cal_bt_sh[15:0]};
    ac6 = {16'd0, cal_bt_sh[31:16]};
    b1  = ext16(cal_bt_sh[47:32]);
    b2  = ext16(cal_bt_sh[63:48]);
    mc  = ext16(cal_mcmd_sh[15:0]);
    md  = ext16(cal_mcmd_sh[31:16]);
    ut  = {16'd0, word[15:0]};
    up  = {8'd0, word[39:16]} >> (8 - oss_sh);
    r   = '{16'd0, 18'd0, ST_DIVZ};

    x1 = sra((ut - ac6) * ac5, 15);
    divisor = x1 + md;
    if (divisor == 0) return r;
    x2 = div_trunc(mc << 11, divisor);
    b5 = x1 + x2;

    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = div_trunc(((ac1 * 32'd4 + x3) << oss_sh) + 32'd2, 32'd4);

    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    b7 = (up - b3) * (32'd50000 >> oss_sh);
    if (b4 == 0) return r;

    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;

    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra((32'd0 - 32'd7357) * p, 16);
    p  = p + sra(x1 + x2 + 32'd3791, 4);

    t = $signed(sra(b5 + 32'd8, 4));
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    ps = $signed(p);
    r.status = ST_OK;
    if (ps < 0) begin
      ps = 0;
      r.status = ST_PSAT;
    end
    if (ps > 262143) begin
      ps = 262143;
      r.status = ST_PSAT;
    end
    r.temp_tenths = t[15:0];
    r.press_pa = ps[17:0];
    return r;
  endfunction

  // Drive input words in bursts separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_words.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict a reading for every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) expected_readings.push_back(compensate(in_tdata));
  end

  // Stall the result side on a rotating pattern, with an occasional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= stall_pattern[cycles % 16];
      if (cycles % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern <= 16'hFFFF;
          default: stall_pattern <= 16'($urandom) | 16'h0101;
        endcase
      end
    end
  end

  // Check each result word against the oldest prediction
  always @(posedge clk) begin
    reading_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[15:0], out_tdata[33:16], status_t'(out_tuser)};
      if (expected_readings.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("ERROR: unexpected result word %h", out_tdata);
      end else begin
        want = expected_readings.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("ERROR: temp %0d/%0d press %0d/%0d status %0d/%0d (exp/act)",
                     $signed(want.temp_tenths), $signed(got.temp_tenths),
                     want.press_pa, got.press_pa, want.status, got.status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_OSS:  oss_sh = value[1:0];
      REG_AC:   cal_ac_sh = value;
      REG_BT:   cal_bt_sh = value;
      REG_MCMD: cal_mcmd_sh = value[31:0];
    endcase
  endtask

  task automatic write_cal(input logic [1:0] oss, input logic [63:0] ac, input logic [63:0] bt,
                           input logic [31:0] mcmd);
    write_reg(REG_OSS, {62'd0, oss});
    write_reg(REG_AC, ac);
    write_reg(REG_BT, bt);
    write_reg(REG_MCMD, {32'd0, mcmd});
  endtask

  // Typical calibration with each coefficient nudged by a random amount
  task automatic write_typical(input logic [1:0] oss, input int spread);
    logic [15:0] c[10];
    c = '{16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd32757, 16'd23153,
          16'd6190, 16'd4, 16'hDDF9, 16'd2868};
    foreach (c[i]) c[i] = c[i] + 16'($urandom_range(0, 2 * spread) - spread);
    write_cal(oss, {c[3], c[2], c[1], c[0]}, {c[7], c[6], c[5], c[4]}, {c[9], c[8]});
  endtask

  function automatic logic [39:0] random_word();
    if ($urandom_range(0, 3) == 0) return 40'({$urandom, $urandom});
    return {16'($urandom_range(15000, 45000)), 8'($urandom),
            16'($urandom_range(20000, 36000))};
  endfunction

  // Let the pipeline drain before touching the registers
  task automatic wait_idle();
    while (pending_words.size() > 0 || in_tvalid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset calibration: every word hits the zero divisor
    pending_words.push_back(40'h0);
    pending_words.push_back(40'hFF_FFFF_FFFF);
    pending_words.push_back({24'h5D2300, 16'd27898});
    wait_idle();

    // Nominal calibration, directed extremes
    write_typical(2'd0, 0);
    pending_words.push_back({24'h5D2300, 16'd27898});
    pending_words.push_back({24'h000000, 16'd0});
    pending_words.push_back({24'hFFFFFF, 16'hFFFF});
    pending_words.push_back({24'h000000, 16'hFFFF});
    pending_words.push_back({24'hFFFFFF, 16'd0});
    pending_words.push_back({24'h800000, 16'h8000});
    pending_words.push_back({24'h5D2300, 16'd23153});
    pending_words.push_back({24'h010000, 16'd27898});
    pending_words.push_back({24'hF00000, 16'd27898});
    wait_idle();

    // Fewest coefficients possible: AC4 zero forces the B4 divisor to zero
    write_cal(2'd3, 64'h0000_C7D1_FFB8_0198, 64'h0004_182E_5A71_7FF5, 32'h0B34_DDF9);
    pending_words.push_back({24'h5D2300, 16'd27898});
    wait_idle();
    // Extremes: most negative MC over a divisor of minus one
    write_reg(REG_MCMD, {32'd0, 32'hFFFF_8000});
    write_reg(REG_BT, 64'h8000_7FFF_0000_0000);
    write_reg(REG_AC, 64'hFFFF_8000_7FFF_8000);
    for (int i = 0; i < 6; i++) pending_words.push_back(random_word());
    wait_idle();
    write_cal(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_7FFF);
    for (int i = 0; i < 6; i++) pending_words.push_back(random_word());
    wait_idle();

    // Random phases under several calibrations
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        2:       write_cal(2'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        default: write_typical(2'(ph), (ph == 0) ? 0 : 300 * ph);
      endcase
      for (int i = 0; i < 110; i++) pending_words.push_back(random_word());
      // Hold the result side long enough to back the pipeline up
      if (ph == 1) holdoff_left = 400;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
design/ptc_pkg.sv
design/ptc_div.sv
design/pressure_temperature_compensation.sv
tb/sv/tb_top.sv
